// File: rtl/swrc_pkg.sv
package swrc_pkg;

  localparam int DW = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [DW-1:0] RATE_SCALE = 32'd1000;
  localparam logic [DW-1:0] DURATION_RESET = 32'd1000;
  localparam logic [DW-1:0] WIDTH_RESET = 32'd100;

  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_DURATION,
    REG_BUCKET_WIDTH
  } cfg_reg_t;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_RING,
    DIV_TIME,
    DIV_RATE
  } div_sel_t;

  typedef struct packed {
    logic     clr;
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_n;
    logic     set_rt;
    logic     rd_cur;
    logic     rec_wr;
    logic     q_init;
    logic     q_rd;
    logic     q_acc;
    logic     mul;
    logic     set_out;
  } swrc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic kind;
    logic q_more;
    logic q_stop;
    logic out_free;
  } swrc_sts_t;

endpackage

// File: rtl/swrc_div.sv
module swrc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [swrc_pkg::DW-1:0] dividend,
  input  logic [swrc_pkg::DW-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [swrc_pkg::DW-1:0] quotient,
  output logic [swrc_pkg::DW-1:0] remainder
);
  import swrc_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;
  logic [DW:0]   trial;
  logic          fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: rtl/swrc_dp.sv
module swrc_dp #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swrc_pkg::DW-1:0]        cfg_wdata,
  input  logic                           in_kind,
  input  logic [swrc_pkg::DW-1:0]        in_event_time,
  input  logic [swrc_pkg::DW-1:0]        in_event_count,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [swrc_pkg::DW-1:0]        out_rate,
  input  swrc_pkg::swrc_cmd_t            cmd,
  output swrc_pkg::swrc_sts_t            sts
);
  import swrc_pkg::*;

  localparam int IW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam logic [NW-1:0] N_MAX = NW'(MAX_BUCKETS);
  localparam logic [DW-1:0] Q_CLAMP = DW'(MAX_BUCKETS - 1);

  logic [2*DW-1:0] mem [MAX_BUCKETS];

  // Control state.
  logic [DW-1:0] dur_r;
  logic [DW-1:0] wid_r;
  logic [IW-1:0] wr_idx_r;
  logic [IW-1:0] wr_idx_nxt;
  logic [IW-1:0] clr_idx_r;
  logic          out_valid_r;

  // Per-item working registers.
  logic            kind_r;
  logic [DW-1:0]   t_r;
  logic [DW-1:0]   cnt_r;
  logic [NW-1:0]   n_r;
  logic [DW-1:0]   rt_r;
  logic [IW-1:0]   idx_r;
  logic [NW-1:0]   i_r;
  logic [DW-1:0]   sum_r;
  logic [DW-1:0]   span_r;
  logic [2*DW-1:0] rd_data_r;
  logic [DW-1:0]   out_rate_r;

  logic [DW-1:0]   weff;
  logic [DW-1:0]   span_eff;
  logic [DW-1:0]   rd_time;
  logic [DW-1:0]   rd_count;
  logic [DW-1:0]   age;
  logic [NW-1:0]   n_m1;
  logic [IW-1:0]   prev_idx;
  logic [IW-1:0]   next_idx;
  logic [DW-1:0]   prod;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [2*DW-1:0] mem_wdata;
  logic            mem_re;
  logic [IW-1:0]   mem_raddr;

  logic [DW-1:0]   div_dvd;
  logic [DW-1:0]   div_dsr;
  logic            div_busy;
  logic            div_done;
  logic [DW-1:0]   div_quo;
  logic [DW-1:0]   div_rem;

  assign weff     = (wid_r == '0) ? DW'(1) : wid_r;
  assign span_eff = (span_r == '0) ? DW'(1) : span_r;
  assign rd_time  = rd_data_r[2*DW-1:DW];
  assign rd_count = rd_data_r[DW-1:0];
  assign age      = rt_r - rd_time;
  assign n_m1     = n_r - NW'(1);
  assign prev_idx = (idx_r == '0) ? n_m1[IW-1:0] : idx_r - IW'(1);
  assign next_idx = (NW'(wr_idx_r) >= n_m1) ? '0 : wr_idx_r + IW'(1);
  assign prod     = sum_r * RATE_SCALE;

  always_comb begin
    case (cmd.div_sel)
      DIV_RING: begin
        div_dvd = dur_r;
        div_dsr = weff;
      end
      DIV_TIME: begin
        div_dvd = t_r;
        div_dsr = weff;
      end
      DIV_RATE: begin
        div_dvd = sum_r;
        div_dsr = span_eff;
      end
      default: begin
        div_dvd = sum_r;
        div_dsr = span_eff;
      end
    endcase
  end

  swrc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Bucket write: a clear step zeroes one bucket; a record beat updates as decided on the current bucket just read.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = wr_idx_r;
    mem_wdata  = {rt_r, cnt_r};
    wr_idx_nxt = wr_idx_r;
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (cmd.rec_wr) begin
      mem_we = 1'b1;
      if (rd_time == '0) begin
        mem_wdata = {rt_r, cnt_r};
      end else if (rd_time == rt_r) begin
        mem_wdata = {rt_r, rd_count + cnt_r};
      end else begin
        mem_waddr  = next_idx;
        wr_idx_nxt = next_idx;
      end
    end
  end

  assign mem_re    = cmd.rd_cur || cmd.q_rd;
  assign mem_raddr = cmd.rd_cur ? wr_idx_r : prev_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r       <= DURATION_RESET;
      wid_r       <= WIDTH_RESET;
      wr_idx_r    <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_DURATION: dur_r <= cfg_wdata;
          REG_BUCKET_WIDTH:    wid_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + IW'(1);
      end
      if (cmd.rec_wr) begin
        wr_idx_r <= wr_idx_nxt;
      end
      if (cmd.set_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      t_r    <= in_event_time;
      cnt_r  <= in_event_count;
    end
    if (cmd.set_n) begin
      n_r <= (div_quo >= Q_CLAMP) ? N_MAX : div_quo[NW-1:0] + NW'(1);
    end
    if (cmd.set_rt) begin
      rt_r <= t_r - div_rem;
    end
    if (cmd.q_init) begin
      idx_r  <= wr_idx_r;
      i_r    <= '0;
      sum_r  <= '0;
      span_r <= '0;
    end else if (cmd.q_rd) begin
      idx_r <= prev_idx;
      i_r   <= i_r + NW'(1);
    end else if (cmd.q_acc) begin
      span_r <= age;
      sum_r  <= sum_r + rd_count;
    end else if (cmd.mul) begin
      sum_r <= prod;
    end
    if (cmd.set_out) begin
      out_rate_r <= div_quo;
    end
  end

  assign sts.clr_last = clr_idx_r == IW'(MAX_BUCKETS - 1);
  assign sts.div_done = div_done;
  assign sts.kind     = kind_r;
  assign sts.q_more   = ({1'b0, i_r} + (NW + 1)'(1)) < {1'b0, n_r};
  assign sts.q_stop   = (rd_time == '0) || (age > dur_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_rate  = out_rate_r;

  ap_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded while the previous one is still held");

  ap_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  ap_acc_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_acc |-> ((rd_time != '0) && (age <= dur_r)))
    else $error("query summed an empty or expired bucket");

  ap_rec_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_wr |-> $past(cmd.rd_cur))
    else $error("record update without a fresh read of the current bucket");

  ap_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    NW'(wr_idx_r) < N_MAX)
    else $error("write index beyond the bucket store");

endmodule

// File: rtl/swrc_ctrl.sv
module swrc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  swrc_pkg::swrc_sts_t sts,
  output swrc_pkg::swrc_cmd_t cmd
);
  import swrc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RING,
    ST_RING_WAIT,
    ST_TIME,
    ST_TIME_WAIT,
    ST_REC_RD,
    ST_REC_WR,
    ST_Q_INIT,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_MUL,
    ST_RATE,
    ST_RATE_WAIT,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_RING;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RING;
        end
      end
      ST_RING: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RING;
        state_nxt     = ST_RING_WAIT;
      end
      ST_RING_WAIT: begin
        if (sts.div_done) begin
          cmd.set_n = 1'b1;
          state_nxt = ST_TIME;
        end
      end
      ST_TIME: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TIME;
        state_nxt     = ST_TIME_WAIT;
      end
      ST_TIME_WAIT: begin
        if (sts.div_done) begin
          cmd.set_rt = 1'b1;
          state_nxt  = (sts.kind == KIND_QUERY) ? ST_Q_INIT : ST_REC_RD;
        end
      end
      ST_REC_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = ST_REC_WR;
      end
      ST_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_nxt  = ST_Q_RD;
      end
      ST_Q_RD: begin
        if (sts.q_more) begin
          cmd.q_rd  = 1'b1;
          state_nxt = ST_Q_CHK;
        end else begin
          state_nxt = ST_Q_MUL;
        end
      end
      ST_Q_CHK: begin
        if (sts.q_stop) begin
          state_nxt = ST_Q_MUL;
        end else begin
          cmd.q_acc = 1'b1;
          state_nxt = ST_Q_RD;
        end
      end
      ST_Q_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RATE;
      end
      ST_RATE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATE;
        state_nxt     = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        cmd.div_sel = DIV_RATE;
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.set_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= state_nxt != ST_IDLE;
    end
  end

  assign in_stall = in_stall_r;

endmodule

// File: rtl/sliding_window_rate_counter.sv
// A record beat is finished before the next beat can enter. A query sums k buckets (up to
// MAX_BUCKETS-1) for its result; the shared divider and the walk over the bucket memory,
// one read step and one check step per bucket, set how long it takes.
// Reset (synchronous, rst_n low) restores the register defaults, then a clearing pass over all
// MAX_BUCKETS buckets empties the bucket memory before the first input beat is taken.
module sliding_window_rate_counter #(
  parameter int MAX_BUCKETS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,

  // Configuration write port: index 0 is window_duration, index 1 is bucket_width.
  input  logic                           cfg_we,
  input  logic [swrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swrc_pkg::DW-1:0]        cfg_wdata,

  // Input channel: one beat is either a record (kind 0) or a query (kind 1).
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [swrc_pkg::DW-1:0]        in_event_time,
  input  logic [swrc_pkg::DW-1:0]        in_event_count,

  // Result channel: one beat per query, none per record.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [swrc_pkg::DW-1:0]        out_rate
);
  import swrc_pkg::*;

  swrc_cmd_t cmd;
  swrc_sts_t sts;

  // The controller sequences each beat through its steps. Every beat first runs two
  // divisions on the shared divider: the window duration by the bucket width, which gives
  // the ring size, and the event time by the bucket width, whose remainder rounds the time
  // down to a bucket boundary. A record then reads the current bucket and, in the next
  // cycle, either adds to it, fills it when it is empty, or advances the ring index and
  // overwrites the next bucket.
  swrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // A query walks back from the bucket before the current one, one memory read and one check per
  // bucket, and stops at an empty bucket or at one older than the window. The sum is scaled
  // by 1000 with 32-bit wrap and divided by the age of the oldest bucket summed (taken as 1
  // when that age is zero). The result sits in an output register, so the next beat is
  // accepted while a finished result still waits to be taken.
  swrc_dp #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_event_time  (in_event_time),
    .in_event_count (in_event_count),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_rate       (out_rate),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// File: bench/tb_sliding_window_rate_counter.sv
`timescale 1ns / 100ps

module tb_sliding_window_rate_counter;
  import swrc_pkg::*;

  // The ring depth of the block under test and of the shadow ring below.
  localparam int RING_MAX = 64;

  localparam logic KIND_RECORD = 1'b0;

  // A record beat and a query at full ring depth each finish within
  // SETTLE_CYCLES. After the last result the block may still be busy with a
  // record, so every pause before a register write waits this long.
  localparam int SETTLE_CYCLES = 250;
  localparam int DRAIN_LIMIT   = 200000;

  // The receiver holds off once, for a long stretch, after this many input
  // beats. Between CALM_FROM and CALM_TO neither side inserts random gaps.
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 700;
  localparam int CALM_FROM   = 600;
  localparam int CALM_TO     = 800;

  localparam int REPORT_MAX = 10;

  typedef struct {
    logic        kind;
    logic [31:0] stamp;
    logic [31:0] count;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_WINDOW_DURATION;
  logic [31:0] cfg_wdata = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_RECORD;
  logic [31:0] in_event_time = '0;
  logic [31:0] in_event_count = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rate;

  sliding_window_rate_counter #(
    .MAX_BUCKETS(RING_MAX)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_event_time (in_event_time),
    .in_event_count(in_event_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rate      (out_rate)
  );

  always #6 clk = ~clk;

  // Beats waiting to be offered, and the rates that accepted queries owe us.
  beat_t       pending_beats[$];
  logic [31:0] rate_expect[$];

  int beats_taken = 0;
  int fail_count = 0;

  // Time cursor used while building well-formed traffic.
  logic [31:0] stamp_cursor = '0;

  // Shadow copy of the register file and of the bucket ring.
  logic [31:0] win_dur;
  logic [31:0] bkt_width;
  logic [31:0] slot_time [RING_MAX];
  logic [31:0] slot_count[RING_MAX];
  logic [5:0]  cur_slot;

  logic        calm;
  logic        hold_started = 1'b0;
  int          hold_left = 0;
  logic        beat_taken;
  logic [31:0] want_rate;

  assign calm = (beats_taken >= CALM_FROM) && (beats_taken < CALM_TO);

  // A width of zero behaves like a width of one.
  function automatic logic [31:0] eff_width();
    return (bkt_width == '0) ? 32'd1 : bkt_width;
  endfunction

  // Ring length: duration / width + 1, computed on 33 bits so that it cannot
  // wrap, then clamped to the physical depth.
  function automatic int ring_len();
    logic [32:0] n;
    n = {1'b0, win_dur / eff_width()} + 33'd1;
    if (n > RING_MAX) n = 33'(RING_MAX);
    return int'(n);
  endfunction

  function automatic logic [31:0] floor_time(input logic [31:0] t);
    logic [31:0] w;
    w = eff_width();
    return (t / w) * w;
  endfunction

  // A record either fills an empty current slot, adds to a slot of the same
  // rounded time, or steps forward (wrapping at the ring end) and overwrites.
  // An index left beyond a shrunken ring wraps to zero on its next step.
  function automatic void log_events(input logic [31:0] t, input logic [31:0] cnt);
    int          n;
    logic [31:0] rt;
    logic [5:0]  idx;
    n = ring_len();
    rt = floor_time(t);
    idx = cur_slot;
    if (slot_time[idx] == '0) begin
      slot_time[idx] = rt;
      slot_count[idx] = cnt;
    end else if (slot_time[idx] == rt) begin
      slot_count[idx] = slot_count[idx] + cnt;
    end else begin
      if (int'(idx) >= n - 1) idx = '0;
      else idx = idx + 6'd1;
      cur_slot = idx;
      slot_time[idx] = rt;
      slot_count[idx] = cnt;
    end
  endfunction

  // A query walks backward over the older slots, never the current one, and
  // stops at an empty slot or at one older than the window. The span is the
  // age of the oldest slot summed; a span of zero is taken as one.
  function automatic logic [31:0] window_rate(input logic [31:0] t);
    int          n;
    int          idx;
    logic [31:0] rt;
    logic [31:0] sum;
    logic [31:0] span;
    logic [31:0] age;
    logic [31:0] scaled;
    n = ring_len();
    rt = floor_time(t);
    idx = int'(cur_slot);
    sum = '0;
    span = '0;
    for (int i = 0; i + 1 < n; i++) begin
      if (idx == 0) idx = n - 1;
      else idx = idx - 1;
      if (slot_time[idx] == '0) break;
      age = rt - slot_time[idx];
      if (age > win_dur) break;
      span = age;
      sum = sum + slot_count[idx];
    end
    if (span == '0) span = 32'd1;
    scaled = sum * RATE_SCALE;
    return scaled / span;
  endfunction

  // Driver. A beat counts as taken at an edge where valid is high and stall
  // is low; its prediction is made right then from the payload on the wires.
  // Valid only drops when no beat is offered, never while one waits.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      beat_taken = in_valid && !in_stall;
      if (beat_taken) begin
        beats_taken <= beats_taken + 1;
        if (in_kind == KIND_QUERY) rate_expect.push_back(window_rate(in_event_time));
        else log_events(in_event_time, in_event_count);
      end
      if (!in_valid || beat_taken) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          in_kind        <= pending_beats[0].kind;
          in_event_time  <= pending_beats[0].stamp;
          in_event_count <= pending_beats[0].count;
          in_valid       <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure. The long hold-off is counted here so that the
  // sender keeps offering beats while the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_started <= 1'b0;
    end else if (!hold_started && beats_taken >= HOLD_AT) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 15);
    end
  end

  // Monitor. Every result beat is matched against the oldest owed rate.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rate_expect.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("[%0t] result with nothing owed: rate %0d", $realtime, out_rate);
        fail_count <= fail_count + 1;
      end else begin
        want_rate = rate_expect.pop_front();
        if (out_rate !== want_rate) begin
          if (fail_count < REPORT_MAX)
            $display("[%0t] rate mismatch: expected %0d, actual %0d",
                     $realtime, want_rate, out_rate);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  task automatic add_beat(input logic kind, input logic [31:0] t, input logic [31:0] cnt);
    beat_t b;
    b.kind = kind;
    b.stamp = t;
    b.count = cnt;
    pending_beats.push_back(b);
  endtask

  // Registers are written only while the block is idle, and the shadow
  // registers follow at the same moment.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_WINDOW_DURATION) win_dur = value;
    else bkt_width = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every beat is taken and every rate has come back, sampling
  // at the falling edge when all of the rising-edge updates have settled.
  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_beats.size() != 0 || in_valid || rate_expect.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly time-ordered traffic around the bucket width, so that the ring
  // fills, wraps and is walked; some beats step back in time and some are
  // pure noise over the full field ranges.
  task automatic queue_random(input int count);
    beat_t       b;
    int          roll;
    int          pick;
    logic [31:0] w;
    logic [31:0] cap;
    w = eff_width();
    cap = (w > 32'h1000_0000) ? 32'hFFFF_FFFF : 2 * w;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        b.kind = 1'($urandom_range(0, 1));
        b.stamp = $urandom;
        b.count = $urandom;
      end else begin
        if (roll < 11) stamp_cursor = stamp_cursor - $urandom_range(0, cap);
        else if (roll < 55) stamp_cursor = stamp_cursor + $urandom_range(0, cap);
        b.stamp = stamp_cursor;
        b.kind = ($urandom_range(0, 99) < 35) ? KIND_QUERY : KIND_RECORD;
        pick = $urandom_range(0, 99);
        if (pick < 70) b.count = $urandom_range(0, 60);
        else if (pick < 90) b.count = $urandom;
        else b.count = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end
      pending_beats.push_back(b);
    end
  endtask

  task automatic run_phase(input logic [31:0] dur, input logic [31:0] w, input int count);
    drain();
    write_reg(REG_WINDOW_DURATION, dur);
    write_reg(REG_BUCKET_WIDTH, w);
    stamp_cursor = $urandom_range(1, 5000);
    queue_random(count);
  endtask

  initial begin
    win_dur = DURATION_RESET;
    bkt_width = WIDTH_RESET;
    cur_slot = '0;
    for (int k = 0; k < RING_MAX; k++) begin
      slot_time[k] = '0;
      slot_count[k] = '0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset settings (window 1000, width 100). The
    // block clears its ring after reset; the handshake covers that pass.
    add_beat(KIND_QUERY,  32'd0,          32'hFFFF_FFFF); // empty ring
    add_beat(KIND_RECORD, 32'd0,          32'd5);         // rounds to 0, stays empty
    add_beat(KIND_QUERY,  32'd50,         32'd0);
    add_beat(KIND_RECORD, 32'd150,        32'd3);         // fills the empty slot
    add_beat(KIND_RECORD, 32'd199,        32'd4);         // same bucket, adds
    add_beat(KIND_RECORD, 32'd250,        32'd7);         // steps forward
    add_beat(KIND_QUERY,  32'd250,        32'd0);
    add_beat(KIND_QUERY,  32'd210,        32'd0);
    for (int k = 3; k <= 14; k++) add_beat(KIND_RECORD, 100 * k, k); // wraps the ring
    add_beat(KIND_QUERY,  32'd1400,       32'd0);
    add_beat(KIND_RECORD, 32'd1400,       32'hFFFF_FFFF); // count wraps
    add_beat(KIND_RECORD, 32'd1490,       32'hFFFF_FFFF);
    add_beat(KIND_RECORD, 32'd1300,       32'd9);         // back in time
    add_beat(KIND_QUERY,  32'd1300,       32'd0);
    add_beat(KIND_QUERY,  32'hFFFF_FFFF,  32'd0);         // every age beyond window
    add_beat(KIND_RECORD, 32'hFFFF_FFFF,  32'd1);
    stamp_cursor = 32'd1500;
    queue_random(140);

    // Each setting is applied on top of the ring left by the one before,
    // so a shrinking ring also leaves the write index beyond its end.
    run_phase(32'd50,        32'd10,        140); // short ring of six
    run_phase(32'hFFFF_FFFF, 32'd1,         140); // bucket count clamped to the depth
    run_phase(32'd1,         32'hFFFF_FFFF, 80);  // a single bucket, queries give 0
    run_phase(32'd7,         32'd0,         140); // width zero behaves as one
    run_phase(32'd640,       32'd10,        140); // 65 buckets clamped to 64
    run_phase(32'd300,       32'd100,       140);
    run_phase(DURATION_RESET, WIDTH_RESET,  140);

    drain();
    if (rate_expect.size() != 0) begin
      $display("%0d rate(s) never arrived", rate_expect.size());
      fail_count = fail_count + rate_expect.size();
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
